[hw/rtl/mecanum_wheel_mixer_unit_defines.svh]
// Assertion macros for the checker file of the wheel mixer.
`ifndef MECANUM_WHEEL_MIXER_UNIT_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MWM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MWM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mwm_pkg.sv]
package mwm_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 15;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEADBAND_LEVEL = 1'b0,
      CSR_TURN_GAIN      = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] DEADBAND_RESET  = 15'd3277;
   localparam logic [CSR_DATA_WIDTH-1:0] TURN_GAIN_RESET = 15'd16384;

   // The turn gain is unsigned Q0.15; its product is rounded by adding one half LSB.
   localparam int GAIN_FRAC_BITS = 15;
   localparam int GAIN_ROUND     = 16384;

   // Lane order of the wheel pipeline.
   localparam int WHEEL_COUNT = 4;
   localparam int LANE_FL     = 0;
   localparam int LANE_FR     = 1;
   localparam int LANE_RL     = 2;
   localparam int LANE_RR     = 3;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] deadband_level;
      logic [CSR_DATA_WIDTH-1:0] turn_gain;
   } csr_type;

endpackage

[hw/rtl/mwm_mix.sv]
module mwm_mix #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  mwm_pkg::csr_type                                  csr,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [SAMPLE_WIDTH-1:0]                           strafe_cmd,
   input  logic [SAMPLE_WIDTH-1:0]                           forward_cmd,
   input  logic [SAMPLE_WIDTH-1:0]                           turn_cmd,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH:0]   out_rem,
   output logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] out_low,
   output logic [mwm_pkg::WHEEL_COUNT-1:0]                   out_sign,
   output logic [SAMPLE_WIDTH:0]                             out_div
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int F  = W - 1;
   localparam int PW = W + mwm_pkg::CSR_DATA_WIDTH;
   localparam int NW = 2 * W + 1;
   localparam int L  = mwm_pkg::WHEEL_COUNT;

   function automatic logic [W:0] dead_zone(input logic [W:0] v, input logic [F-1:0] lvl);
      logic [W:0] mag;
      mag = v[W] ? -v : v;
      dead_zone = (mag < {2'b00, lvl}) ? '0 : v;
   endfunction

   // Stage 1: negate the stick axes and multiply the turn magnitude by the gain.
   logic           s1_valid_ff;
   logic [W:0]     s1_right_ff, s1_right_in;
   logic [W:0]     s1_fwd_ff, s1_fwd_in;
   logic [PW-1:0]  s1_prod_ff, s1_prod_in;
   logic           s1_neg_ff;
   logic [W-1:0]   turn_mag;

   // Stage 2: round the turn term, apply the deadband and form the wheel sums.
   logic                 s2_valid_ff;
   logic [L-1:0][W+1:0]  s2_wheel_ff, s2_wheel_in;
   logic [PW-1:0]        turn_rnd;
   logic [W:0]           cw_mag, cw_val, cw_db, right_db, fwd_db;
   logic [W+1:0]         cw_x, right_x, fwd_x;
   logic [F+14:0]        level_ext;
   logic [F-1:0]         level;

   // Stage 3: wheel magnitudes, the largest one and the divisor choice.
   logic                 s3_valid_ff;
   logic [L-1:0][W:0]    s3_mag_ff, s3_mag_in;
   logic [L-1:0]         s3_sign_ff, s3_sign_in;
   logic [W:0]           s3_div_ff, s3_div_in;
   logic [L-1:0][W+1:0]  wheel_neg;
   logic [W:0]           max01, max23, max_all, one_val;

   // Stage 4: build the rounded dividend and split it for the divider.
   logic                 s4_valid_ff;
   logic [L-1:0][W:0]    s4_rem_ff, s4_rem_in;
   logic [L-1:0][W-1:0]  s4_low_ff, s4_low_in;
   logic [L-1:0]         s4_sign_ff;
   logic [W:0]           s4_div_ff;
   logic [L-1:0][NW-1:0] dividend;

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_right_in = -{strafe_cmd[W-1], strafe_cmd};
      s1_fwd_in   = -{forward_cmd[W-1], forward_cmd};
      turn_mag    = turn_cmd[W-1] ? -turn_cmd : turn_cmd;
      s1_prod_in  = PW'(turn_mag) * PW'(csr.turn_gain);
   end

   always_comb begin
      level_ext = {csr.deadband_level, {F{1'b0}}};
      level     = level_ext[F+14:15];
      turn_rnd  = s1_prod_ff + PW'(mwm_pkg::GAIN_ROUND);
      cw_mag    = {1'b0, turn_rnd[PW-1:mwm_pkg::GAIN_FRAC_BITS]};
      cw_val    = s1_neg_ff ? -cw_mag : cw_mag;
      cw_db     = dead_zone(cw_val, level);
      right_db  = dead_zone(s1_right_ff, level);
      fwd_db    = dead_zone(s1_fwd_ff, level);
      cw_x      = {cw_db[W], cw_db};
      right_x   = {right_db[W], right_db};
      fwd_x     = {fwd_db[W], fwd_db};
      s2_wheel_in[mwm_pkg::LANE_FL] = fwd_x + cw_x + right_x;
      s2_wheel_in[mwm_pkg::LANE_FR] = fwd_x - cw_x - right_x;
      s2_wheel_in[mwm_pkg::LANE_RL] = fwd_x + cw_x - right_x;
      s2_wheel_in[mwm_pkg::LANE_RR] = fwd_x - cw_x + right_x;
   end

   always_comb begin
      for (int k = 0; k < L; k++) begin
         wheel_neg[k]  = -s2_wheel_ff[k];
         s3_sign_in[k] = s2_wheel_ff[k][W+1];
         s3_mag_in[k]  = s3_sign_in[k] ? wheel_neg[k][W:0] : s2_wheel_ff[k][W:0];
      end
      max01   = (s3_mag_in[0] > s3_mag_in[1]) ? s3_mag_in[0] : s3_mag_in[1];
      max23   = (s3_mag_in[2] > s3_mag_in[3]) ? s3_mag_in[2] : s3_mag_in[3];
      max_all = (max01 > max23) ? max01 : max23;
      one_val = (W+1)'(1) << F;
      // Below full scale the divisor is one, which returns the wheel unchanged.
      s3_div_in = (max_all > one_val) ? max_all : one_val;
   end

   always_comb begin
      for (int k = 0; k < L; k++) begin
         dividend[k]  = (NW'(s3_mag_ff[k]) << F) + NW'(s3_div_ff >> 1);
         s4_rem_in[k] = dividend[k][NW-1:W];
         s4_low_in[k] = dividend[k][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_right_ff <= s1_right_in;
         s1_fwd_ff   <= s1_fwd_in;
         s1_prod_ff  <= s1_prod_in;
         s1_neg_ff   <= turn_cmd[W-1];
      end
      if (s2_ready) begin
         s2_wheel_ff <= s2_wheel_in;
      end
      if (s3_ready) begin
         s3_mag_ff  <= s3_mag_in;
         s3_sign_ff <= s3_sign_in;
         s3_div_ff  <= s3_div_in;
      end
      if (s4_ready) begin
         s4_rem_ff  <= s4_rem_in;
         s4_low_ff  <= s4_low_in;
         s4_sign_ff <= s3_sign_ff;
         s4_div_ff  <= s3_div_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_rem   = s4_rem_ff;
   assign out_low   = s4_low_ff;
   assign out_sign  = s4_sign_ff;
   assign out_div   = s4_div_ff;

endmodule

[hw/rtl/mwm_div_stage.sv]
module mwm_div_stage #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH:0]   in_rem,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] in_low,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] in_quot,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0]                   in_sign,
   input  logic [SAMPLE_WIDTH:0]                             in_div,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH:0]   out_rem,
   output logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] out_low,
   output logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] out_quot,
   output logic [mwm_pkg::WHEEL_COUNT-1:0]                   out_sign,
   output logic [SAMPLE_WIDTH:0]                             out_div
);

   localparam int W = SAMPLE_WIDTH;
   localparam int L = mwm_pkg::WHEEL_COUNT;

   // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
   logic                valid_ff;
   logic [L-1:0][W:0]   rem_ff, rem_in;
   logic [L-1:0][W-1:0] low_ff, low_in;
   logic [L-1:0][W-1:0] quot_ff, quot_in;
   logic [L-1:0]        sign_ff;
   logic [W:0]          div_ff;
   logic [L-1:0][W+1:0] trial, diff;
   logic [L-1:0]        fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int k = 0; k < L; k++) begin
         trial[k]   = {in_rem[k], in_low[k][W-1]};
         diff[k]    = trial[k] - {1'b0, in_div};
         fits[k]    = !diff[k][W+1];
         rem_in[k]  = fits[k] ? diff[k][W:0] : trial[k][W:0];
         low_in[k]  = in_low[k] << 1;
         quot_in[k] = {in_quot[k][W-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
         sign_ff <= in_sign;
         div_ff  <= in_div;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_quot  = quot_ff;
   assign out_sign  = sign_ff;
   assign out_div   = div_ff;

endmodule

[hw/rtl/mwm_out.sv]
module mwm_out #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0][SAMPLE_WIDTH-1:0] in_quot,
   input  logic [mwm_pkg::WHEEL_COUNT-1:0]                   in_sign,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]                           rsp_front_left_drive,
   output logic [SAMPLE_WIDTH-1:0]                           rsp_front_right_drive,
   output logic [SAMPLE_WIDTH-1:0]                           rsp_rear_left_drive,
   output logic [SAMPLE_WIDTH-1:0]                           rsp_rear_right_drive
);

   localparam int W = SAMPLE_WIDTH;
   localparam int F = W - 1;
   localparam int L = mwm_pkg::WHEEL_COUNT;

   logic                rsp_valid_ff;
   logic [L-1:0][W-1:0] drive_ff, drive_in;

   assign in_ready = !rsp_valid_ff || !rsp_stall;

   // The quotient never exceeds full scale, so its top bit alone marks +1.0.
   always_comb begin
      for (int k = 0; k < L; k++) begin
         if (in_sign[k]) begin
            drive_in[k] = -in_quot[k];
         end else if (in_quot[k][W-1]) begin
            drive_in[k] = {1'b0, {F{1'b1}}};
         end else begin
            drive_in[k] = in_quot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_front_left_drive  = drive_ff[mwm_pkg::LANE_FL];
   assign rsp_front_right_drive = drive_ff[mwm_pkg::LANE_FR];
   assign rsp_rear_left_drive   = drive_ff[mwm_pkg::LANE_RL];
   assign rsp_rear_right_drive  = drive_ff[mwm_pkg::LANE_RR];

endmodule

[hw/rtl/mecanum_wheel_mixer_unit.sv]
// Cartesian mixer for a four-wheel mecanum drive, Q1.(SAMPLE_WIDTH-1) samples.
// Request channel (req_*): one transaction carries strafe, forward and turn
// stick values; it is taken at a clock edge where req_valid is high and
// req_stall is low. Response channel (rsp_*): one transaction carries the four
// wheel commands, taken where rsp_valid is high and rsp_stall is low.
// The path from request to response runs through four mixing stages, one
// divider stage per quotient bit and the output register. Throughput is one
// transaction per cycle while the receiver does not stall; the divider is fully
// pipelined with four lanes sharing one divisor.
// When the receiver stalls, the response holds and each stage keeps its
// contents; empty stages still fill, so requests are taken until the pipeline
// is full, and then req_stall rises. Nothing is dropped or repeated.
// Synchronous reset empties every stage and loads the register defaults
// (deadband 0.1, turn gain 0.5). The csr_* port writes one register at a time,
// chosen by csr_index; write them only while no transaction is in flight.
module mecanum_wheel_mixer_unit #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [mwm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mwm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_strafe_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_forward_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_turn_cmd,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_front_left_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_front_right_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_rear_left_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_rear_right_drive
);

   localparam int W = SAMPLE_WIDTH;
   localparam int L = mwm_pkg::WHEEL_COUNT;

   // Configuration registers. An index outside the register list is ignored.
   mwm_pkg::csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.deadband_level <= mwm_pkg::DEADBAND_RESET;
         csr_ff.turn_gain      <= mwm_pkg::TURN_GAIN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            mwm_pkg::CSR_DEADBAND_LEVEL: csr_ff.deadband_level <= csr_wdata;
            mwm_pkg::CSR_TURN_GAIN:      csr_ff.turn_gain      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Links between the mixer, the divider stages and the output register.
   // Link 0 is the mixer output, link W feeds the output register.
   logic                mix_ready;
   logic                link_valid [0:W];
   logic                link_ready [0:W];
   logic [L-1:0][W:0]   link_rem   [0:W];
   logic [L-1:0][W-1:0] link_low   [0:W];
   logic [L-1:0][W-1:0] link_quot  [0:W];
   logic [L-1:0]        link_sign  [0:W];
   logic [W:0]          link_div   [0:W];

   assign req_stall = !mix_ready;

   mwm_mix #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_mix (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .in_valid    (req_valid),
      .in_ready    (mix_ready),
      .strafe_cmd  (req_strafe_cmd),
      .forward_cmd (req_forward_cmd),
      .turn_cmd    (req_turn_cmd),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_rem     (link_rem[0]),
      .out_low     (link_low[0]),
      .out_sign    (link_sign[0]),
      .out_div     (link_div[0])
   );

   // The quotient builds up from zero, one bit per divider stage.
   assign link_quot[0] = '0;

   for (genvar g = 0; g < W; g++) begin : g_div
      mwm_div_stage #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_rem    (link_rem[g]),
         .in_low    (link_low[g]),
         .in_quot   (link_quot[g]),
         .in_sign   (link_sign[g]),
         .in_div    (link_div[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_rem   (link_rem[g+1]),
         .out_low   (link_low[g+1]),
         .out_quot  (link_quot[g+1]),
         .out_sign  (link_sign[g+1]),
         .out_div   (link_div[g+1])
      );
   end

   mwm_out #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_out (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (link_valid[W]),
      .in_ready              (link_ready[W]),
      .in_quot               (link_quot[W]),
      .in_sign               (link_sign[W]),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_front_left_drive  (rsp_front_left_drive),
      .rsp_front_right_drive (rsp_front_right_drive),
      .rsp_rear_left_drive   (rsp_rear_left_drive),
      .rsp_rear_right_drive  (rsp_rear_right_drive)
   );

endmodule

[hw/rtl/mwm_checker.sv]
`include "mecanum_wheel_mixer_unit_defines.svh"

module mwm_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_front_left_drive,
   input logic [SAMPLE_WIDTH-1:0] rsp_front_right_drive,
   input logic [SAMPLE_WIDTH-1:0] rsp_rear_left_drive,
   input logic [SAMPLE_WIDTH-1:0] rsp_rear_right_drive
);

   // After reset the pipeline is empty and ready for a transaction.
   `MWM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "pipeline not empty after reset")

   // With the output register empty every stage can advance, so requests are taken.
   `MWM_ASSERT_IMPLY(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall, "request stalled with empty output")

   // A stalled response stays offered.
   `MWM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

   // A stalled response keeps its wheel commands.
   `MWM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_front_left_drive) && $stable(rsp_front_right_drive) && $stable(rsp_rear_left_drive) && $stable(rsp_rear_right_drive), "response changed while stalled")

endmodule

bind mecanum_wheel_mixer_unit mwm_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mwm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_front_left_drive  (rsp_front_left_drive),
   .rsp_front_right_drive (rsp_front_right_drive),
   .rsp_rear_left_drive   (rsp_rear_left_drive),
   .rsp_rear_right_drive  (rsp_rear_right_drive)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   // The block is built at its default sample width, so samples are Q1.15.
   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
   localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
   // Request to response latency, taken from the stages listed at the head of the top level.
   localparam int LATENCY = SAMPLE_WIDTH + 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 10;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int DIRECTED_COUNT = 22;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [mwm_pkg::CSR_DATA_WIDTH-1:0] csr_word_type;

   // The four wheel commands of one response, front left in the top slice.
   typedef struct packed {
      sample_type fl;
      sample_type fr;
      sample_type rl;
      sample_type rr;
   } wheel_set_type;

   // One row of the directed table. Where typed_in is set, the wheel values
   // of the row are the expected response; otherwise the mixer predictor
   // supplies it.
   typedef struct {
      int strafe;
      int fwd;
      int turn;
      bit typed_in;
      int fl;
      int fr;
      int rl;
      int rr;
   } directed_row_type;

   // All rows run with the reset register values: deadband 3277, gain 0.5.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Centered sticks give a standing robot.
      '{0, 0, 0, 1'b1, 0, 0, 0, 0},
      // Negating the most negative forward value gives exactly +1.0, which
      // saturates to the largest code on every wheel.
      '{0, -32768, 0, 1'b1, 32767, 32767, 32767, 32767},
      '{0, 32767, 0, 1'b1, -32767, -32767, -32767, -32767},
      '{-32768, 0, 0, 1'b1, 32767, -32768, -32768, 32767},
      '{32767, 0, 0, 1'b1, -32767, 32767, 32767, -32767},
      // Full turn at half gain.
      '{0, 0, 32767, 1'b1, 16384, -16384, 16384, -16384},
      '{0, 0, -32768, 1'b1, -16384, 16384, -16384, 16384},
      // A magnitude equal to the deadband passes, one below it is cleared.
      '{0, -3277, 0, 1'b1, 3277, 3277, 3277, 3277},
      '{0, -3276, 0, 1'b1, 0, 0, 0, 0},
      '{3277, 3276, 0, 1'b1, -3277, 3277, 3277, -3277},
      '{1, -1, 1, 1'b1, 0, 0, 0, 0},
      // Largest wheel is 2.0, so everything is halved.
      '{-32768, -32768, 0, 1'b1, 32767, 0, 0, 32767},
      // Largest wheel exactly 1.0: no scaling, only the output clamp.
      '{0, -16384, 32767, 1'b1, 32767, 0, 32767, 0},
      // Gain rounding right at the deadband edge, with ties away from zero.
      '{0, 0, 6554, 1'b0, 0, 0, 0, 0},
      '{0, 0, 6553, 1'b0, 0, 0, 0, 0},
      '{0, 0, 6551, 1'b0, 0, 0, 0, 0},
      '{-32768, -32768, 32767, 1'b0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 1'b0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 1'b0, 0, 0, 0, 0},
      '{12345, -23456, 30000, 1'b0, 0, 0, 0, 0},
      '{-20000, -20000, 0, 1'b0, 0, 0, 0, 0},
      '{-30000, 10001, -12345, 1'b0, 0, 0, 0, 0}
   };

   string wheel_names [mwm_pkg::WHEEL_COUNT] = '{"left_fore", "right_fore", "left_aft",
                                                 "right_aft"};

   // Every input of the block starts at a known value; reset is high.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [mwm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = mwm_pkg::CSR_DEADBAND_LEVEL;
   csr_word_type csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type req_strafe_cmd = '0;
   sample_type req_forward_cmd = '0;
   sample_type req_turn_cmd = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sample_type rsp_front_left_drive;
   sample_type rsp_front_right_drive;
   sample_type rsp_rear_left_drive;
   sample_type rsp_rear_right_drive;

   // Shadow copies of the two registers, updated whenever the test writes them.
   csr_word_type deadband_mirror = mwm_pkg::DEADBAND_RESET;
   csr_word_type gain_mirror = mwm_pkg::TURN_GAIN_RESET;

   // Wheel sets still owed by the block, oldest first.
   wheel_set_type pending_wheels [$];
   wheel_set_type got_wheels;
   wheel_set_type want_wheels;

   int mismatch_count = 0;
   int idle_cycles = 0;
   // Idle rates in percent for the sender gaps and the receiver stalls.
   int gap_pct = 20;
   int stall_pct = 20;
   int stall_left = 0;

   mecanum_wheel_mixer_unit #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_strafe_cmd(req_strafe_cmd),
      .req_forward_cmd(req_forward_cmd),
      .req_turn_cmd(req_turn_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_front_left_drive(rsp_front_left_drive),
      .rsp_front_right_drive(rsp_front_right_drive),
      .rsp_rear_left_drive(rsp_rear_left_drive),
      .rsp_rear_right_drive(rsp_rear_right_drive)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint magnitude_of(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // A component strictly inside the deadband is forced to zero.
   function automatic longint drop_small(longint v, longint level);
      return (magnitude_of(v) < level) ? 0 : v;
   endfunction

   // Predicts the four wheel commands for one stick transaction under the
   // given register values. All arithmetic is done at 64 bits so that the
   // negated most negative input and the raw wheel sums never wrap.
   function automatic wheel_set_type mix_wheels(sample_type strafe, sample_type fwd_stick,
                                                sample_type turn, csr_word_type deadband,
                                                csr_word_type gain);
      longint right;
      longint forward;
      longint clockwise;
      longint level;
      longint turn_mag;
      longint peak;
      longint v;
      longint sums [mwm_pkg::WHEEL_COUNT];
      wheel_set_type mixed;
      right = -longint'(strafe);
      forward = -longint'(fwd_stick);
      // The register is Q0.15; the samples are at least that wide.
      level = longint'(deadband) << (FRAC_BITS - mwm_pkg::GAIN_FRAC_BITS);
      turn_mag = (magnitude_of(longint'(turn)) * longint'(gain) + mwm_pkg::GAIN_ROUND)
                 >>> mwm_pkg::GAIN_FRAC_BITS;
      clockwise = (turn < 0) ? -turn_mag : turn_mag;
      right = drop_small(right, level);
      clockwise = drop_small(clockwise, level);
      forward = drop_small(forward, level);
      sums[mwm_pkg::LANE_FL] = forward + clockwise + right;
      sums[mwm_pkg::LANE_FR] = forward - clockwise - right;
      sums[mwm_pkg::LANE_RL] = forward + clockwise - right;
      sums[mwm_pkg::LANE_RR] = forward - clockwise + right;
      peak = 0;
      for (int k = 0; k < mwm_pkg::WHEEL_COUNT; k++) begin
         if (magnitude_of(sums[k]) > peak) begin
            peak = magnitude_of(sums[k]);
         end
      end
      for (int k = 0; k < mwm_pkg::WHEEL_COUNT; k++) begin
         v = sums[k];
         // Rescale by the largest magnitude, rounding half away from zero.
         if (peak > ONE_VAL) begin
            v = ((magnitude_of(v) << FRAC_BITS) + (peak >> 1)) / peak;
            if (sums[k] < 0) begin
               v = -v;
            end
         end
         if (v > ONE_VAL - 1) begin
            v = ONE_VAL - 1;
         end
         if (v < -ONE_VAL) begin
            v = -ONE_VAL;
         end
         mixed[(mwm_pkg::WHEEL_COUNT-1-k)*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
            v[SAMPLE_WIDTH-1:0];
      end
      return mixed;
   endfunction

   // Draws one stick value. Half of the draws cover the whole code space; the
   // rest aim at the full-scale codes, the deadband edge and small values, or draw a random magnitude.
   function automatic sample_type pick_sample(longint level);
      longint v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v = longint'($urandom);
         end
         5: begin
            case ($urandom_range(0, 4))
               0: v = -ONE_VAL;
               1: v = ONE_VAL - 1;
               2: v = 0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         6: begin
            v = level + longint'($urandom_range(0, 2)) - 1;
         end
         7: begin
            v = longint'($urandom_range(0, 511)) - 256;
         end
         default: begin
            v = longint'($urandom_range(0, 32767));
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         v = -v;
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   // Offers one stick transaction, possibly after a random gap, and holds it
   // until the block takes it. The expected wheels are queued at that edge.
   task automatic send_command(input sample_type strafe, input sample_type fwd_stick,
                               input sample_type turn, input bit typed_in,
                               input wheel_set_type typed_wheels);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_strafe_cmd <= strafe;
      req_forward_cmd <= fwd_stick;
      req_turn_cmd <= turn;
      do @(posedge clock); while (req_stall);
      if (typed_in) begin
         pending_wheels.push_back(typed_wheels);
      end else begin
         pending_wheels.push_back(mix_wheels(strafe, fwd_stick, turn, deadband_mirror,
                                             gain_mirror));
      end
   endtask

   // Stops offering and waits until every owed wheel set has come back.
   // Every transaction yields a response, so an empty queue means an idle block.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_wheels.size() != 0) @(posedge clock);
   endtask

   // Writes the deadband register and then the gain register, enable held high.
   task automatic write_settings(input csr_word_type deadband, input csr_word_type gain);
      csr_write_en <= 1'b1;
      csr_index <= mwm_pkg::CSR_DEADBAND_LEVEL;
      csr_wdata <= deadband;
      @(posedge clock);
      csr_index <= mwm_pkg::CSR_TURN_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_write_en <= 1'b0;
      deadband_mirror = deadband;
      gain_mirror = gain;
   endtask

   // Receiver stalls come in bursts. A zero rate clears any
   // burst in progress so that the stall-free stretches really are free.
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 9) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker: each accepted wheel transaction is compared lane by
   // lane against the oldest expectation. The values sampled here are the
   // ones that stood before the edge, so the check is free of races.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_wheels = '{rsp_front_left_drive, rsp_front_right_drive,
                        rsp_rear_left_drive, rsp_rear_right_drive};
         if (pending_wheels.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no wheel transaction, actual %0d %0d %0d %0d", $time,
                     got_wheels.fl, got_wheels.fr, got_wheels.rl, got_wheels.rr);
         end else begin
            want_wheels = pending_wheels.pop_front();
            for (int k = 0; k < mwm_pkg::WHEEL_COUNT; k++) begin
               if (got_wheels[(mwm_pkg::WHEEL_COUNT-1-k)*SAMPLE_WIDTH +: SAMPLE_WIDTH] !==
                   want_wheels[(mwm_pkg::WHEEL_COUNT-1-k)*SAMPLE_WIDTH +: SAMPLE_WIDTH])
               begin
                  mismatch_count++;
                  $display("%0t: %s expected %0d actual %0d", $time, wheel_names[k],
                     $signed(want_wheels[(mwm_pkg::WHEEL_COUNT-1-k)*SAMPLE_WIDTH +:
                                         SAMPLE_WIDTH]),
                     $signed(got_wheels[(mwm_pkg::WHEEL_COUNT-1-k)*SAMPLE_WIDTH +:
                                        SAMPLE_WIDTH]));
               end
            end
         end
      end
   end

   // Watchdog: too many cycles in a row without a handshake on either side
   // means the block has hung or lost a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Main sequence: reset, the directed table under the reset register values,
   // then random phases. Each phase drains the block, writes new register
   // values and picks new idle rates. The extreme settings come first, one
   // phase runs with no idling at all, one runs under heavy idling, and the
   // last phase is idle-free as well.
   initial begin
      int phase;
      csr_word_type db_setting;
      csr_word_type gain_setting;
      wheel_set_type typed;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed = '{sample_type'(directed_rows[i].fl), sample_type'(directed_rows[i].fr),
                   sample_type'(directed_rows[i].rl), sample_type'(directed_rows[i].rr)};
         send_command(sample_type'(directed_rows[i].strafe),
                      sample_type'(directed_rows[i].fwd),
                      sample_type'(directed_rows[i].turn), directed_rows[i].typed_in, typed);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // The sender holds off here until every response has come back.
         drain_pipeline();
         case (phase)
            0: begin
               db_setting = '0;
               gain_setting = '1;
            end
            1: begin
               db_setting = '1;
               gain_setting = '0;
            end
            2: begin
               db_setting = '0;
               gain_setting = '0;
            end
            3: begin
               db_setting = '1;
               gain_setting = '1;
            end
            default: begin
               // Odd phases keep the deadband small so that most sticks pass.
               if (phase % 2 == 1) begin
                  db_setting = csr_word_type'($urandom_range(0, 4000));
               end else begin
                  db_setting = csr_word_type'($urandom_range(0, 32767));
               end
               gain_setting = csr_word_type'($urandom_range(0, 32767));
            end
         endcase
         write_settings(db_setting, gain_setting);
         if (phase == 5 || phase == PHASE_COUNT - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else if (phase == 6) begin
            gap_pct = 50;
            stall_pct = 50;
         end else begin
            gap_pct = $urandom_range(5, 35);
            stall_pct = $urandom_range(5, 35);
         end
         repeat (ITEMS_PER_PHASE) begin
            send_command(pick_sample(longint'(deadband_mirror)),
                         pick_sample(longint'(deadband_mirror)),
                         pick_sample(longint'(deadband_mirror)), 1'b0, '0);
         end
      end

      // Let the last responses land, then watch a little longer for strays.
      drain_pipeline();
      repeat (LATENCY + 8) @(posedge clock);
      if (pending_wheels.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d wheel transactions never arrived", $time,
                  pending_wheels.size());
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
